/* src/fdsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsf_pkg
// Shared widths and constants for the frame delta spike filter.
// ----------------------------------------------------------------------------
package fdsf_pkg;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned DEPTH_DEFAULT = 8;

   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

endpackage : fdsf_pkg
`default_nettype wire

/* src/fdsf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdsf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fdsf_ram #(
   parameter int unsigned WIDTH = fdsf_pkg::DATA_W,
   parameter int unsigned DEPTH = fdsf_pkg::DEPTH_DEFAULT,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : fdsf_ram
`default_nettype wire

/* src/frame_delta_spike_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Steps: accept, scan for the window peak, drain, sum and write, decide into the
// result register. The scan is serial over the single read port of the window
// RAM, one entry per cycle; no new sample is taken until the decide step is done.
// A new sample is taken while the previous result still waits on rsp_stall.
// Reset (synchronous): carry and write position clear, every window entry is
// marked empty and reads as all ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
// frame_delta_spike_filter
// Frame-time spike filter: sample plus carry is cut to the peak of the previous
// DEPTH raw samples, halved above twice it; the excess is carried to later frames.
// ----------------------------------------------------------------------------
module frame_delta_spike_filter #(
   parameter int unsigned DEPTH = fdsf_pkg::DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic [fdsf_pkg::DATA_W-1:0] req_delta_us,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic [fdsf_pkg::DATA_W-1:0] rsp_filtered_us
);

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned DW = fdsf_pkg::DATA_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_SUM,
      ST_DECIDE
   } state_type;

   state_type        state_ff;
   logic [IW-1:0]    cnt_ff;
   logic [IW-1:0]    wpos_ff;
   logic [DEPTH-1:0] filled_ff;
   logic             live_ff;        // read data from the RAM is due this cycle
   logic             live_filled_ff;
   logic [DW-1:0]    sample_ff;
   logic [DW-1:0]    peak_ff;
   logic [DW-1:0]    sum_ff;
   logic [DW-1:0]    carry_ff;
   logic             rsp_valid_ff;
   logic [DW-1:0]    rsp_data_ff;

   logic [DW-1:0]    rd_data;
   logic [DW-1:0]    entry;
   logic             req_fire;
   logic             out_free;
   logic [DW:0]      wide_sum;
   logic [DW-1:0]    sat_sum;
   logic             within_peak;
   logic             within_twice;

   fdsf_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (state_ff == ST_SUM),
      .wr_addr (wpos_ff),
      .wr_data (sample_ff),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // an entry never written since reset reads as all ones
   assign entry = live_filled_ff ? rd_data : fdsf_pkg::ALL_ONES;

   assign wide_sum     = {1'b0, sample_ff} + {1'b0, carry_ff};
   assign sat_sum      = wide_sum[DW] ? fdsf_pkg::ALL_ONES : wide_sum[DW-1:0];
   assign within_peak  = (sum_ff <= peak_ff);
   assign within_twice = ({1'b0, sum_ff} <= {peak_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         wpos_ff        <= '0;
         filled_ff      <= '0;
         live_ff        <= 1'b0;
         live_filled_ff <= 1'b0;
         carry_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         live_ff <= 1'b0;
         if (live_ff && (entry > peak_ff)) begin
            peak_ff <= entry;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  sample_ff <= req_delta_us;
                  peak_ff   <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               live_ff        <= 1'b1;
               live_filled_ff <= filled_ff[cnt_ff];
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sum_ff             <= sat_sum;
               filled_ff[wpos_ff] <= 1'b1;
               wpos_ff            <= (wpos_ff == LAST_IDX) ? '0 : wpos_ff + 1'b1;
               state_ff           <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (within_peak) begin
                     carry_ff    <= '0;
                     rsp_data_ff <= sum_ff;
                  end else if (within_twice) begin
                     carry_ff    <= sum_ff - peak_ff;
                     rsp_data_ff <= peak_ff;
                  end else begin
                     carry_ff    <= sum_ff >> 1;
                     rsp_data_ff <= sum_ff >> 1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filtered_us = rsp_data_ff;

   // a result appears only out of the decide step
   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DECIDE))
      else $error("result raised outside decide step");

   // an accepted beat starts the window scan at entry zero
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN) && (cnt_ff == '0))
      else $error("accepted beat did not start the scan");

   // a pass-through result clears the carry
   a_carry_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && out_free && within_peak |=> (carry_ff == '0))
      else $error("carry not cleared on pass-through");

   // the decide step never overwrites a result still held by the sink
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && (state_ff == ST_DECIDE) |=> $stable(rsp_data_ff))
      else $error("pending result overwritten");

   // write position stays inside the ring
   a_wpos_range: assert property (@(posedge clock) disable iff (reset)
      wpos_ff <= LAST_IDX)
      else $error("write position out of range");

endmodule : frame_delta_spike_filter
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_delta_spike_filter. A local model of the
// peak window, carry and saturation predicts every smoothed delta. Directed
// frame sequences come first, then random frame-time streams at three scales
// with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned       DATA_W      = fdsf_pkg::DATA_W;
   localparam logic [DATA_W-1:0] ALL_ONES    = fdsf_pkg::ALL_ONES;
   localparam int unsigned       RING        = fdsf_pkg::DEPTH_DEFAULT;
   localparam int unsigned       BLOCK_SPAN  = RING + 4;
   localparam int unsigned       CYCLE_LIMIT = 400000;
   localparam int unsigned       MAX_REPORTS = 10;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_delta_us = '0;
   logic              rsp_valid;
   logic              rsp_stall    = 1'b0;
   logic [DATA_W-1:0] rsp_filtered_us;

   // model state
   logic [DATA_W-1:0] ring_model [RING];
   int unsigned       ring_wr;
   logic [DATA_W-1:0] carry_model;
   logic [DATA_W-1:0] expected_filtered [$];
   logic [DATA_W-1:0] want_filtered;

   bit                idle_on = 1'b1;
   int unsigned       stall_left = 0;
   int unsigned       samples_sent = 0;
   int unsigned       directed_count = 0;
   int unsigned       results_checked = 0;
   int unsigned       fail_count = 0;
   int unsigned       cycle_count = 0;

   frame_delta_spike_filter #(
      .DEPTH(RING)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_delta_us    (req_delta_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_filtered_us (rsp_filtered_us)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_filtered.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Peak is taken before the new delta lands in the ring; the twice-peak
   // compare runs at 33 bits.
   function automatic logic [DATA_W-1:0] smooth_delta(input logic [DATA_W-1:0] delta);
      logic [DATA_W-1:0] peak;
      logic [DATA_W:0]   wide;
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] smoothed;
      peak = '0;
      foreach (ring_model[k]) begin
         if (ring_model[k] > peak) peak = ring_model[k];
      end
      ring_model[ring_wr] = delta;
      ring_wr = (ring_wr + 1) % RING;
      wide = {1'b0, delta} + {1'b0, carry_model};
      sum  = wide[DATA_W] ? ALL_ONES : wide[DATA_W-1:0];
      if (sum <= peak) begin
         carry_model = '0;
         smoothed    = sum;
      end else if ({1'b0, sum} <= {peak, 1'b0}) begin
         carry_model = sum - peak;
         smoothed    = peak;
      end else begin
         carry_model = sum >> 1;
         smoothed    = carry_model;
      end
      return smoothed;
   endfunction

   // One frame time around base: mostly jitter, some spikes and outliers.
   function automatic logic [DATA_W-1:0] frame_delta(input logic [DATA_W-1:0] base);
      logic [63:0] v;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         v = 64'(base) + 64'($urandom_range(0, base / 8)) - 64'(base / 16);
      else if (roll < 72)
         v = 64'(base) * $urandom_range(2, 4);
      else if (roll < 80)
         v = 64'(base) + 64'(base / 2);
      else if (roll < 86)
         v = 64'(base) * 2 + 64'($urandom_range(0, 2));  // near the twice-peak edge
      else if (roll < 90)
         v = '0;
      else if (roll < 94)
         v = 64'(ALL_ONES);
      else
         v = 64'($urandom);
      return (v > 64'(ALL_ONES)) ? ALL_ONES : v[DATA_W-1:0];
   endfunction

   task automatic send_delta(input logic [DATA_W-1:0] delta);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_delta_us <= delta;
      do @(posedge clock); while (req_stall);
      expected_filtered.push_back(smooth_delta(delta));
      samples_sent++;
   endtask

   // Ring starts all ones, so everything passes through, extremes included.
   task automatic test_fresh_ring();
      idle_on = 1'b1;
      send_delta('0);
      send_delta(ALL_ONES);
      send_delta(32'd1);
      send_delta(32'h8000_0000);
      send_delta(32'h7FFF_FFFF);
      repeat (3) send_delta(32'd16667);
   endtask

   // Steady 60 Hz ring, then exact twice-peak, a clear, a big spike, and
   // saturation of the carried sum.
   task automatic test_spike_cases();
      repeat (RING) send_delta(32'd16667);
      send_delta(32'd33334);
      send_delta('0);
      send_delta(32'd100000);
      send_delta(ALL_ONES);
      send_delta(ALL_ONES);
   endtask

   task automatic test_random_frames(input int unsigned count);
      logic [DATA_W-1:0] base;
      int unsigned left;
      int unsigned run;
      left = count;
      while (left > 0) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 2))
            0: base = $urandom_range(1000, 60000);
            1: base = $urandom_range(32'h6000_0000, 32'h9000_0000);
            default: base = $urandom;
         endcase
         run = $urandom_range(20, 60);
         if (run > left) run = left;
         repeat (run) send_delta(frame_delta(base));
         left -= run;
      end
   endtask

   // Sender holds off until the pipe is empty, then resumes.
   task automatic test_drain_pause();
      idle_on = 1'b1;
      repeat (12) send_delta(frame_delta(32'd16667));
      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (12) send_delta(frame_delta(32'd16667));
   endtask

   // result side: check each beat, then stall the next one for a drawn count
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_filtered.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("[%0t] unexpected result beat: filtered_us=0x%08h",
                           $time, rsp_filtered_us);
            end else begin
               want_filtered = expected_filtered.pop_front();
               if (rsp_filtered_us !== want_filtered) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("[%0t] filtered_us mismatch: expected 0x%08h, got 0x%08h",
                              $time, want_filtered, rsp_filtered_us);
               end
            end
            stall_left = idle_on ? $urandom_range(0, 10) : 0;
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin
      foreach (ring_model[k]) ring_model[k] = ALL_ONES;
      ring_wr     = 0;
      carry_model = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_fresh_ring();
      test_spike_cases();
      directed_count = samples_sent;
      test_random_frames(400);
      test_drain_pause();
      test_random_frames(400);

      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (4 * BLOCK_SPAN) @(posedge clock);
      if (expected_filtered.size() != 0) begin
         fail_count += expected_filtered.size();
         $display("%0d expected results never arrived", expected_filtered.size());
      end

      $display("Sent %0d frame deltas (%0d directed: fresh ring, twice-peak, halving,",
               samples_sent, directed_count);
      $display("saturation; rest random streams at three scales), checked %0d beats, %0d failures",
               results_checked, fail_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
